/* rtl/csme_pkg.sv */
// Shared types, constants and string tables for the C source markup escaper.
// Used by csme_ctrl, csme_dp and c_source_markup_escaper_core; no dependencies.
package csme_pkg;

    localparam int COLUMN_WIDTH     = 12;
    localparam int MAX_TAB_INTERVAL = 32;
    localparam int TI_W             = 6;
    localparam int TW_W             = 9;
    localparam int DVD_W            = COLUMN_WIDTH + 1;
    localparam int V_W              = COLUMN_WIDTH + TW_W;
    // decimal digits needed for a V_W-bit value
    localparam int BCD_DIGITS       = 7;
    localparam int TLEN_W           = 6;
    localparam int APB_ADDR_W       = 4;

    localparam logic [COLUMN_WIDTH-1:0] COL_MAX = {COLUMN_WIDTH{1'b1}};

    localparam logic [1:0] REG_TAB_BY_SPACES = 2'd0;
    localparam logic [1:0] REG_TAB_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_TAB_WIDTH     = 2'd2;
    localparam logic [1:0] REG_TAB_UNIT      = 2'd3;

    localparam logic [3:0] STAT_OK            = 4'd0;
    localparam logic [3:0] STAT_STR_TAB       = 4'd1;
    localparam logic [3:0] STAT_STR_BS_TAB    = 4'd2;
    localparam logic [3:0] STAT_STR_UNTERM    = 4'd3;
    localparam logic [3:0] STAT_STR_CONT      = 4'd4;
    localparam logic [3:0] STAT_CHR_TAB       = 4'd5;
    localparam logic [3:0] STAT_CHR_UNTERM    = 4'd6;
    localparam logic [3:0] STAT_EOF_COMMENT   = 4'd7;
    localparam logic [3:0] STAT_EOF_STRING    = 4'd8;
    localparam logic [3:0] STAT_EOF_CHAR      = 4'd9;
    localparam logic [3:0] STAT_FATAL_AT      = 4'd10;
    localparam logic [3:0] STAT_FATAL_OPENER  = 4'd11;
    localparam logic [3:0] STAT_FATAL_INSERT  = 4'd12;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;

    typedef enum logic [4:0] {
        S_CHAR, S_SLASH, S_STAR, S_T, S_NP, S_DOLDOL, S_DLB, S_DRB, S_BSQ,
        S_OPEN_L, S_OPEN_S, S_OPEN_CC, S_OPEN_CPP, S_OPEN_C, S_CLOSE,
        S_CLOSE_NL, S_REOPEN_C, S_REOPEN_S, S_ESC_BS, S_ESC_Q, S_TAB_ESC,
        S_SLASH_CLOSE, S_SLASH_NL
    } str_id_t;

    typedef struct packed {
        logic              step;
        logic              eof;
        logic [7:0]        ch;
        logic              tab_start;
        logic              emit;
        logic              emit_tab;
        logic [TLEN_W-1:0] tab_idx;
        logic [7:0]        byte_val;
        logic              byte_valid;
        logic [3:0]        status;
        logic              last;
    } dp_cmd_t;

    typedef struct packed {
        logic              tab_done;
        logic [TLEN_W-1:0] tab_len;
        logic              out_free;
    } dp_sts_t;

    function automatic logic [3:0] str_len(str_id_t id);
        logic [3:0] n;
        case (id)
            S_NP:                           n = 4'd5;
            S_BSQ:                          n = 4'd4;
            S_OPEN_L, S_OPEN_S, S_OPEN_C:   n = 4'd5;
            S_OPEN_CC, S_OPEN_CPP:          n = 4'd7;
            S_REOPEN_C, S_REOPEN_S:         n = 4'd8;
            S_CLOSE_NL, S_TAB_ESC,
            S_SLASH_CLOSE:                  n = 4'd3;
            S_DOLDOL, S_DLB, S_DRB, S_CLOSE,
            S_ESC_BS, S_ESC_Q, S_SLASH_NL:  n = 4'd2;
            default:                        n = 4'd1;
        endcase
        return n;
    endfunction

    // byte i of a markup string; for the one-byte entry S_CHAR it is the source byte
    function automatic logic [7:0] str_char(str_id_t id, logic [2:0] i, logic [7:0] ch);
        logic [63:0] s;
        logic [3:0]  pos;
        logic [63:0] sh;
        case (id)
            S_CHAR:        s = {56'd0, ch};
            S_SLASH:       s = 64'("/");
            S_STAR:        s = 64'("*");
            S_T:           s = 64'("t");
            S_NP:          s = 64'("\n@NP\n");
            S_DOLDOL:      s = 64'("$$");
            S_DLB:         s = 64'("${");
            S_DRB:         s = 64'("$}");
            S_BSQ:         s = 64'("\"\\\\\"");
            S_OPEN_L:      s = 64'("{@L \"");
            S_OPEN_S:      s = 64'("{@S \"");
            S_OPEN_CC:     s = 64'("{@C \"/*");
            S_OPEN_CPP:    s = 64'("{@C \"//");
            S_OPEN_C:      s = 64'("{@C \"");
            S_CLOSE:       s = 64'("\"}");
            S_CLOSE_NL:    s = 64'("\"}\n");
            S_REOPEN_C:    s = 64'("\"}\n{@C \"");
            S_REOPEN_S:    s = 64'("\"}\n{@S \"");
            S_ESC_BS:      s = 64'("\\\\");
            S_ESC_Q:       s = 64'("\\\"");
            S_TAB_ESC:     s = 64'("\\\\t");
            S_SLASH_CLOSE: s = 64'("/\"}");
            S_SLASH_NL:    s = 64'("/\n");
            default:       s = 64'd0;
        endcase
        pos = str_len(id) - 4'd1 - {1'b0, i};
        sh  = s >> {pos[2:0], 3'b000};
        return sh[7:0];
    endfunction

endpackage

/* rtl/csme_ctrl.sv */
// Controller: lexical state, per-word output plan and byte sequencing.
// Depends on csme_pkg; drives csme_dp through dp_cmd_t and reads dp_sts_t.
module csme_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [7:0]        s_source_byte,
    output csme_pkg::dp_cmd_t cmd,
    input  csme_pkg::dp_sts_t sts
);
    import csme_pkg::*;

    typedef enum logic [3:0] {
        L_CODE, L_SLASH, L_SLASH_STAR, L_SLASH_SLASH, L_CCOM, L_CCOM_NL,
        L_CPPCOM, L_INS, L_INS_STAR, L_CPPINS, L_CSTAR, L_STR, L_STR_BS,
        L_CHR, L_CHR_BS, L_DEAD
    } lex_t;

    typedef enum logic [1:0] {C_IDLE, C_TABW, C_EMIT, C_STAT} ctl_t;

    ctl_t       state_reg, state_next;
    lex_t       lex_reg, lex_next;
    logic [7:0] ch_reg, ch_next;
    str_id_t    slot_id_reg [4];
    str_id_t    slot_id_next [4];
    logic [3:0] slot_vld_reg, slot_vld_next;
    logic [3:0] status_reg, status_next;
    logic       first_reg, first_next;
    logic [1:0] cur_reg, cur_next;
    logic [TLEN_W-1:0] idx_reg, idx_next;

    // decoded plan for the word at the input
    logic    pre_v, s1_v, tab_v, s3_v, run_inner;
    str_id_t pre_id, s1_id, s3_id;
    lex_t    dec_next, inner;
    logic [3:0] dec_stat;
    logic [3:0] dec_vld;

    logic       acc;
    logic       cur_is_tab, at_end, last_byte;
    str_id_t    cur_id;
    logic [TLEN_W-1:0] cur_len;
    logic [3:0] later_v;

    function automatic logic [1:0] first_set(logic [3:0] v);
        logic [1:0] k;
        if (v[0]) k = 2'd0;
        else if (v[1]) k = 2'd1;
        else if (v[2]) k = 2'd2;
        else k = 2'd3;
        return k;
    endfunction

    assign s_ready = (state_reg == C_IDLE);
    assign acc     = s_valid && s_ready;

    always_comb begin
        logic [7:0] c;
        c         = s_source_byte;
        pre_v     = 1'b0;
        pre_id    = S_CHAR;
        s1_v      = 1'b0;
        s1_id     = S_CHAR;
        tab_v     = 1'b0;
        s3_v      = 1'b0;
        s3_id     = S_CHAR;
        dec_stat  = STAT_OK;
        dec_next  = lex_reg;
        inner     = lex_reg;
        run_inner = 1'b1;
        if (s_kind) begin
            run_inner = 1'b0;
            dec_next  = L_CODE;
            case (lex_reg)
                L_SLASH: begin
                    s1_v = 1'b1; s1_id = S_SLASH_NL;
                end
                L_CCOM, L_CCOM_NL, L_CPPCOM, L_CSTAR: begin
                    s1_v = 1'b1; s1_id = S_CLOSE_NL; dec_stat = STAT_EOF_COMMENT;
                end
                L_SLASH_STAR, L_SLASH_SLASH: dec_stat = STAT_FATAL_OPENER;
                L_INS, L_INS_STAR, L_CPPINS: dec_stat = STAT_FATAL_INSERT;
                L_STR, L_STR_BS: begin
                    s1_v = 1'b1; s1_id = S_CLOSE_NL; dec_stat = STAT_EOF_STRING;
                end
                L_CHR, L_CHR_BS: begin
                    s1_v = 1'b1; s1_id = S_CLOSE_NL; dec_stat = STAT_EOF_CHAR;
                end
                default: ;
            endcase
        end else begin
            case (lex_reg)
                L_SLASH: begin
                    if (c == "*") begin
                        run_inner = 1'b0; dec_next = L_SLASH_STAR;
                    end else if (c == "/") begin
                        run_inner = 1'b0; dec_next = L_SLASH_SLASH;
                    end else begin
                        pre_v = 1'b1; pre_id = S_SLASH; inner = L_CODE;
                    end
                end
                L_SLASH_STAR: begin
                    if (c == "@") begin
                        run_inner = 1'b0; dec_next = L_INS;
                    end else begin
                        pre_v = 1'b1; pre_id = S_OPEN_CC; inner = L_CCOM;
                    end
                end
                L_SLASH_SLASH: begin
                    if (c == "@") begin
                        run_inner = 1'b0; dec_next = L_CPPINS;
                    end else begin
                        pre_v = 1'b1; pre_id = S_OPEN_CPP; inner = L_CPPCOM;
                    end
                end
                L_CCOM_NL: begin
                    pre_v = 1'b1; pre_id = S_REOPEN_C; inner = L_CCOM;
                end
                L_DEAD: run_inner = 1'b0;
                default: ;
            endcase
            if (run_inner) begin
                dec_next = inner;
                case (inner)
                    L_CODE: begin
                        s1_v = 1'b1;
                        if (c == CH_FF) s1_id = S_NP;
                        else if (c == CH_TAB) begin
                            s1_v = 1'b0; tab_v = 1'b1;
                        end else if (c == "#") s1_id = S_DOLDOL;
                        else if (c == "\\") s1_id = S_BSQ;
                        else if (c == "{") s1_id = S_DLB;
                        else if (c == "}") s1_id = S_DRB;
                        else if (c == "@") begin
                            s1_v = 1'b0; dec_stat = STAT_FATAL_AT; dec_next = L_DEAD;
                        end else if (c == "/") begin
                            s1_v = 1'b0; dec_next = L_SLASH;
                        end else if (c == "'") begin
                            s1_id = S_OPEN_L; dec_next = L_CHR;
                        end else if (c == "\"") begin
                            s1_id = S_OPEN_S; dec_next = L_STR;
                        end
                    end
                    L_CCOM, L_CSTAR, L_CPPCOM: begin
                        s1_v = 1'b1;
                        dec_next = (inner == L_CPPCOM) ? L_CPPCOM : L_CCOM;
                        if (inner == L_CSTAR && c == "/") begin
                            s1_id = S_SLASH_CLOSE; dec_next = L_CODE;
                        end else if (inner != L_CPPCOM && c == "*") begin
                            dec_next = L_CSTAR;
                        end else if (c == CH_TAB) begin
                            s1_id = S_CLOSE; tab_v = 1'b1; s3_v = 1'b1; s3_id = S_OPEN_C;
                        end else if (c == CH_NL) begin
                            if (inner == L_CCOM) begin
                                s1_v = 1'b0; dec_next = L_CCOM_NL;
                            end else if (inner == L_CSTAR) s1_id = S_REOPEN_C;
                            else begin
                                s1_id = S_CLOSE_NL; dec_next = L_CODE;
                            end
                        end else if (c == "\\") s1_id = S_ESC_BS;
                        else if (c == "\"") s1_id = S_ESC_Q;
                    end
                    L_INS: begin
                        if (c == "*") dec_next = L_INS_STAR;
                        else s1_v = 1'b1;
                    end
                    L_INS_STAR: begin
                        if (c == "/") dec_next = L_CODE;
                        else begin
                            s1_v = 1'b1; s1_id = S_STAR;
                            if (c != "*") begin
                                s3_v = 1'b1; dec_next = L_INS;
                            end
                        end
                    end
                    L_CPPINS: begin
                        s1_v = 1'b1;
                        if (c == CH_NL) dec_next = L_CODE;
                    end
                    L_STR: begin
                        s1_v = 1'b1;
                        if (c == CH_TAB) begin
                            s1_id = S_TAB_ESC; dec_stat = STAT_STR_TAB;
                        end else if (c == "\\") begin
                            s1_id = S_ESC_BS; dec_next = L_STR_BS;
                        end else if (c == "\"") begin
                            s1_id = S_CLOSE; dec_next = L_CODE;
                        end else if (c == CH_NL) begin
                            s1_id = S_CLOSE_NL; dec_stat = STAT_STR_UNTERM; dec_next = L_CODE;
                        end
                    end
                    L_STR_BS: begin
                        s1_v = 1'b1; dec_next = L_STR;
                        if (c == CH_TAB) begin
                            s1_id = S_T; dec_stat = STAT_STR_BS_TAB;
                        end else if (c == "\\") s1_id = S_ESC_BS;
                        else if (c == "\"") s1_id = S_ESC_Q;
                        else if (c == CH_NL) begin
                            s1_id = S_REOPEN_S; dec_stat = STAT_STR_CONT;
                        end
                    end
                    L_CHR: begin
                        s1_v = 1'b1;
                        if (c == CH_TAB) begin
                            s1_id = S_TAB_ESC; dec_stat = STAT_CHR_TAB;
                        end else if (c == "\\") begin
                            s1_id = S_ESC_BS; dec_next = L_CHR_BS;
                        end else if (c == "\"") s1_id = S_ESC_Q;
                        else if (c == CH_NL) begin
                            s1_id = S_CLOSE_NL; dec_stat = STAT_CHR_UNTERM; dec_next = L_CODE;
                        end else if (c == "'") begin
                            s1_id = S_CLOSE; dec_next = L_CODE;
                        end
                    end
                    L_CHR_BS: begin
                        s1_v = 1'b1; dec_next = L_CHR;
                        if (c == "\"") s1_id = S_ESC_Q;
                        else if (c == "\\") s1_id = S_ESC_BS;
                        else if (c == CH_NL) begin
                            s1_id = S_CLOSE_NL; dec_stat = STAT_CHR_UNTERM; dec_next = L_CODE;
                        end
                    end
                    default: ;
                endcase
            end
        end
        dec_vld = {s3_v, tab_v, s1_v, pre_v};
    end

    // emission of the current plan slot
    assign cur_is_tab = (cur_reg == 2'd2);
    assign cur_id     = slot_id_reg[cur_reg];
    assign cur_len    = cur_is_tab ? sts.tab_len : {{(TLEN_W-4){1'b0}}, str_len(cur_id)};
    assign at_end     = (idx_reg == cur_len - {{(TLEN_W-1){1'b0}}, 1'b1});
    assign later_v    = slot_vld_reg & (4'b1110 << cur_reg);
    assign last_byte  = at_end && (later_v == 4'b0000);

    always_comb begin
        cmd            = '0;
        cmd.step       = acc && !s_kind && (lex_reg != L_DEAD);
        cmd.eof        = acc && s_kind;
        cmd.ch         = s_source_byte;
        cmd.tab_start  = acc && !s_kind && tab_v;
        cmd.tab_idx    = idx_reg;
        cmd.emit_tab   = cur_is_tab;
        if (state_reg == C_EMIT) begin
            cmd.emit       = sts.out_free;
            cmd.byte_val   = str_char(cur_id, idx_reg[2:0], ch_reg);
            cmd.byte_valid = 1'b1;
            cmd.status     = first_reg ? status_reg : STAT_OK;
            cmd.last       = last_byte;
        end else if (state_reg == C_STAT) begin
            cmd.emit     = sts.out_free;
            cmd.emit_tab = 1'b0;
            cmd.status   = status_reg;
            cmd.last     = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        lex_next      = lex_reg;
        ch_next       = ch_reg;
        slot_id_next  = slot_id_reg;
        slot_vld_next = slot_vld_reg;
        status_next   = status_reg;
        first_next    = first_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        case (state_reg)
            C_IDLE: begin
                if (acc) begin
                    lex_next        = dec_next;
                    ch_next         = s_source_byte;
                    slot_id_next[0] = pre_id;
                    slot_id_next[1] = s1_id;
                    slot_id_next[2] = S_CHAR;
                    slot_id_next[3] = s3_id;
                    slot_vld_next   = dec_vld;
                    status_next     = dec_stat;
                    first_next      = 1'b1;
                    cur_next        = first_set(dec_vld);
                    idx_next        = '0;
                    if (tab_v && !s_kind) state_next = C_TABW;
                    else if (dec_vld != 4'b0000) state_next = C_EMIT;
                    else if (dec_stat != STAT_OK) state_next = C_STAT;
                end
            end
            C_TABW: begin
                if (sts.tab_done) state_next = C_EMIT;
            end
            C_EMIT: begin
                if (sts.out_free) begin
                    first_next = 1'b0;
                    if (!at_end) idx_next = idx_reg + {{(TLEN_W-1){1'b0}}, 1'b1};
                    else if (last_byte) state_next = C_IDLE;
                    else begin
                        cur_next = first_set(later_v);
                        idx_next = '0;
                    end
                end
            end
            C_STAT: begin
                if (sts.out_free) state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= C_IDLE;
            lex_reg      <= L_CODE;
            slot_vld_reg <= 4'b0000;
            status_reg   <= STAT_OK;
            first_reg    <= 1'b0;
            cur_reg      <= 2'd0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            lex_reg      <= lex_next;
            slot_vld_reg <= slot_vld_next;
            status_reg   <= status_next;
            first_reg    <= first_next;
            cur_reg      <= cur_next;
            idx_reg      <= idx_next;
        end
        ch_reg      <= ch_next;
        slot_id_reg <= slot_id_next;
    end

endmodule

/* rtl/csme_dp.sv */
// Datapath: configuration registers, column counter, tab-stop divider,
// multipliers, binary-to-decimal converter and output register. Uses csme_pkg.
module csme_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  csme_pkg::dp_cmd_t             cmd,
    output csme_pkg::dp_sts_t             sts,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csme_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_byte_valid,
    output logic [3:0]                    m_status,
    output logic                          m_last
);
    import csme_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_DIV, T_MUL, T_BCD} tab_t;

    logic              tab_by_spaces_reg;
    logic [TI_W-1:0]   tab_interval_reg;
    logic [TW_W-1:0]   tab_width_reg;
    logic [7:0]        tab_unit_reg;

    logic [COLUMN_WIDTH-1:0] column_reg, column_next, col_stepped;

    tab_t                t_state_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [TI_W-1:0]     rem_reg;
    logic [TI_W-1:0]     ti_reg;
    logic [4:0]          cnt_reg;
    logic [V_W-1:0]      v_reg;
    logic [4*BCD_DIGITS-1:0] bcd_reg;
    logic [TLEN_W-1:0]   n_reg;
    logic                done_reg;

    logic                m_valid_reg;
    logic [7:0]          m_out_byte_reg;
    logic                m_byte_valid_reg;
    logic [3:0]          m_status_reg;
    logic                m_last_reg;

    logic [TI_W-1:0]     ti_eff;
    logic [TI_W:0]       trial;
    logic                ge;
    logic [COLUMN_WIDTH-1:0] q;
    logic [COLUMN_WIDTH+TI_W-1:0] target;
    logic [4*BCD_DIGITS-1:0] bcd_adj;
    logic [2:0]          nd;
    logic [TLEN_W-1:0]   tab_len;
    logic [7:0]          tab_byte;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_TAB_BY_SPACES: prdata = {31'd0, tab_by_spaces_reg};
            REG_TAB_INTERVAL:  prdata = {{(32-TI_W){1'b0}}, tab_interval_reg};
            REG_TAB_WIDTH:     prdata = {{(32-TW_W){1'b0}}, tab_width_reg};
            REG_TAB_UNIT:      prdata = {24'd0, tab_unit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // clamp the interval to 1..MAX_TAB_INTERVAL
    always_comb begin
        if (tab_interval_reg == '0) ti_eff = TI_W'(1);
        else if (tab_interval_reg > TI_W'(MAX_TAB_INTERVAL)) ti_eff = TI_W'(MAX_TAB_INTERVAL);
        else ti_eff = tab_interval_reg;
    end

    assign col_stepped = (cmd.ch == CH_NL) ? '0 :
                         (column_reg == COL_MAX) ? column_reg
                                                 : column_reg + COLUMN_WIDTH'(1);

    assign trial  = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge     = trial >= {1'b0, ti_reg};
    assign q      = dvd_reg[COLUMN_WIDTH-1:0];
    assign target = (COLUMN_WIDTH+TI_W)'(q) * (COLUMN_WIDTH+TI_W)'(ti_reg);

    always_comb begin
        bcd_adj = bcd_reg;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (bcd_reg[4*k +: 4] >= 4'd5) bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
        end
    end

    always_comb begin
        column_next = column_reg;
        if (cmd.eof) column_next = '0;
        else if (cmd.step) column_next = col_stepped;
        else if (t_state_reg == T_MUL) begin
            column_next = (target > (COLUMN_WIDTH+TI_W)'(COL_MAX)) ? COL_MAX
                                                                  : target[COLUMN_WIDTH-1:0];
        end
    end

    // digits of the integer part, at least one
    always_comb begin
        nd = 3'd1;
        for (int k = 1; k < BCD_DIGITS; k++) begin
            if (bcd_reg[4*k +: 4] != 4'd0) nd = 3'(k);
        end
    end

    assign tab_len = tab_by_spaces_reg ? n_reg : TLEN_W'(8) + {{(TLEN_W-3){1'b0}}, nd};

    always_comb begin
        logic [TLEN_W-1:0] i, ip_end;
        logic [2:0]        dsel;
        i      = cmd.tab_idx;
        ip_end = TLEN_W'(3) + {{(TLEN_W-3){1'b0}}, nd};
        dsel   = 3'(ip_end - i);
        if (tab_by_spaces_reg) tab_byte = " ";
        else if (i == TLEN_W'(0)) tab_byte = " ";
        else if (i == TLEN_W'(1)) tab_byte = "$";
        else if (i == TLEN_W'(2)) tab_byte = ">";
        else if (i < ip_end) tab_byte = {4'h3, bcd_reg[4*dsel +: 4]};
        else if (i == ip_end) tab_byte = ".";
        else if (i == ip_end + TLEN_W'(1)) tab_byte = {4'h3, bcd_reg[3:0]};
        else if (i == ip_end + TLEN_W'(2)) tab_byte = tab_unit_reg;
        else if (i == ip_end + TLEN_W'(3)) tab_byte = "t";
        else tab_byte = " ";
    end

    assign sts.tab_done = done_reg;
    assign sts.tab_len  = tab_len;
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_by_spaces_reg <= 1'b1;
            tab_interval_reg  <= TI_W'(8);
            tab_width_reg     <= TW_W'(30);
            tab_unit_reg      <= "f";
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_TAB_BY_SPACES: tab_by_spaces_reg <= pwdata[0];
                REG_TAB_INTERVAL:  tab_interval_reg  <= pwdata[TI_W-1:0];
                REG_TAB_WIDTH:     tab_width_reg     <= pwdata[TW_W-1:0];
                REG_TAB_UNIT:      tab_unit_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= '0;
            t_state_reg <= T_IDLE;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            column_reg <= column_next;
            if (cmd.tab_start) begin
                // divide (stepped column + interval - 1) by the interval: one quotient bit a cycle
                dvd_reg     <= {1'b0, col_stepped} + {{(DVD_W-TI_W){1'b0}}, ti_eff}
                               - {{(DVD_W-1){1'b0}}, 1'b1};
                rem_reg     <= '0;
                ti_reg      <= ti_eff;
                cnt_reg     <= '0;
                done_reg    <= 1'b0;
                t_state_reg <= T_DIV;
            end else begin
                case (t_state_reg)
                    T_DIV: begin
                        rem_reg <= ge ? TI_W'(trial - {1'b0, ti_reg}) : trial[TI_W-1:0];
                        dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'(DVD_W-1)) t_state_reg <= T_MUL;
                    end
                    T_MUL: begin
                        n_reg   <= TLEN_W'(target - {{TI_W{1'b0}}, column_reg}
                                          + (COLUMN_WIDTH+TI_W)'(1));
                        v_reg   <= V_W'(q) * V_W'(tab_width_reg);
                        bcd_reg <= '0;
                        cnt_reg <= '0;
                        if (tab_by_spaces_reg) begin
                            done_reg    <= 1'b1;
                            t_state_reg <= T_IDLE;
                        end else begin
                            t_state_reg <= T_BCD;
                        end
                    end
                    T_BCD: begin
                        bcd_reg <= {bcd_adj[4*BCD_DIGITS-2:0], v_reg[V_W-1]};
                        v_reg   <= {v_reg[V_W-2:0], 1'b0};
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'(V_W-1)) begin
                            done_reg    <= 1'b1;
                            t_state_reg <= T_IDLE;
                        end
                    end
                    default: t_state_reg <= T_IDLE;
                endcase
            end
        end
    end

    // output register: load a word when free, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_out_byte_reg   <= cmd.emit_tab ? tab_byte : cmd.byte_val;
            m_byte_valid_reg <= cmd.byte_valid;
            m_status_reg     <= cmd.status;
            m_last_reg       <= cmd.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_byte_valid = m_byte_valid_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

endmodule

/* rtl/c_source_markup_escaper_core.sv */
// Top level of the C source markup escaper: controller plus datapath.
// Depends on csme_pkg, csme_ctrl and csme_dp.
//
// Takes one C source byte (or an end-of-file word) at a time and returns its
// markup as a run of byte words, the first carrying a status code and the last
// flagged; a status with no markup comes as a single word without a byte, and
// a word with neither yields no output. One word is taken when the block is
// idle, and the next is not taken until the last output word of the previous
// one has been loaded into the output register. A tab additionally waits for
// the tab-stop divider (one quotient bit a cycle), the multiply step and the
// registered done flag to the controller, and in tab-stop token mode for the
// binary-to-decimal converter. Output bytes wait in a one-word output register for the consumer.
module c_source_markup_escaper_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [7:0]                      s_source_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_byte,
    output logic                            m_byte_valid,
    output logic [3:0]                      m_status,
    output logic                            m_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csme_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import csme_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    csme_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_source_byte (s_source_byte),
        .cmd           (cmd),
        .sts           (sts)
    );

    csme_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_status     (m_status),
        .m_last       (m_last)
    );

endmodule
